### sv/pim_pkg.sv
package pim_pkg;

  // Field widths fixed by the request format
  localparam int unsigned PRIO_W   = 3;
  localparam int unsigned STATUS_W = 3;

  // Request commands
  localparam logic CMD_LOCK   = 1'b0;
  localparam logic CMD_UNLOCK = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED = 3'd0,
    ST_QUEUED  = 3'd1,
    ST_FREED   = 3'd2,
    ST_HANDED  = 3'd3,
    ST_ERROR   = 3'd4
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // request taken, waiter memory read issued
    logic commit;   // state update and result register load
  } pim_ctrl_t;

endpackage

### sv/pim_if.sv
// Request channel: lock / unlock from the running thread
interface pim_req_if #(
  parameter int unsigned ID_BITS = 5
);
  logic               valid;
  logic               ready;
  logic               command;
  logic [ID_BITS-1:0] thread_id;
  logic [2:0]         thread_priority;

  modport source (output valid, command, thread_id, thread_priority, input ready);
  modport sink   (input valid, command, thread_id, thread_priority, output ready);
endinterface

// Result channel: what the scheduler must change
interface pim_rsp_if #(
  parameter int unsigned ID_BITS = 5
);
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic               owner_valid;
  logic [ID_BITS-1:0] owner_id;
  logic [2:0]         owner_priority;
  logic               owner_priority_changed;
  logic               released_valid;
  logic [ID_BITS-1:0] released_id;
  logic [2:0]         released_priority;

  modport source (output valid, status, owner_valid, owner_id, owner_priority,
                  owner_priority_changed, released_valid, released_id,
                  released_priority, input ready);
  modport sink   (input valid, status, owner_valid, owner_id, owner_priority,
                  owner_priority_changed, released_valid, released_id,
                  released_priority, output ready);
endinterface

### sv/pim_ctrl.sv
module pim_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pim_pkg::pim_ctrl_t ctrl_o
);
  import pim_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   capture, commit;

  // Handshake decode
  assign in_ready_o = (state_q == S_IDLE);
  assign capture    = in_valid_i && in_ready_o;
  assign commit     = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (capture) state_d = S_EXEC;
      S_EXEC: if (commit)  state_d = S_IDLE;
      default:             state_d = S_IDLE;
    endcase
  end

  // Result register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit)           out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ctrl_o.capture = capture;
  assign ctrl_o.commit  = commit;

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("result not presented after commit");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    capture |=> !in_ready_o)
    else $error("request taken while another is in work");

endmodule

### sv/pim_dp.sv
module pim_dp #(
  parameter int unsigned NUM_PRIORITIES = 8,
  parameter int unsigned LEVEL_DEPTH    = 8,
  parameter int unsigned THREAD_ID_BITS = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pim_pkg::pim_ctrl_t        ctrl_i,
  input  logic                      command_i,
  input  logic [THREAD_ID_BITS-1:0] thread_id_i,
  input  logic [2:0]                thread_priority_i,
  output logic [2:0]                status_o,
  output logic                      owner_valid_o,
  output logic [THREAD_ID_BITS-1:0] owner_id_o,
  output logic [2:0]                owner_priority_o,
  output logic                      owner_priority_changed_o,
  output logic                      released_valid_o,
  output logic [THREAD_ID_BITS-1:0] released_id_o,
  output logic [2:0]                released_priority_o
);
  import pim_pkg::*;

  localparam int unsigned LVW   = $clog2(NUM_PRIORITIES);
  localparam int unsigned SLW   = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int unsigned CNW   = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned WORDS = NUM_PRIORITIES * LEVEL_DEPTH;
  localparam int unsigned AW    = $clog2(WORDS);
  localparam int unsigned IDW   = THREAD_ID_BITS;
  localparam int unsigned MAXP  = (NUM_PRIORITIES - 1 > 7) ? 7 : NUM_PRIORITIES - 1;

  localparam logic [PRIO_W-1:0] MAXP_C = PRIO_W'(MAXP);
  localparam logic [CNW-1:0]    FULL_C = CNW'(LEVEL_DEPTH);
  localparam logic [SLW-1:0]    LAST_C = SLW'(LEVEL_DEPTH - 1);
  localparam logic [AW-1:0]     LD_C   = AW'(LEVEL_DEPTH);

  // Request registers
  logic              cmd_q;
  logic [IDW-1:0]    tid_q;
  logic [PRIO_W-1:0] prio_q;
  logic [LVW-1:0]    lvl_q;
  logic [LVW-1:0]    top_q;

  // Owner state
  logic              own_q, own_d;
  logic [IDW-1:0]    hid_q, hid_d;
  logic [PRIO_W-1:0] hbase_q, hbase_d;
  logic [PRIO_W-1:0] hcur_q, hcur_d;

  // Per-level ring pointers and fill
  logic [SLW-1:0] head_q [NUM_PRIORITIES];
  logic [SLW-1:0] tail_q [NUM_PRIORITIES];
  logic [CNW-1:0] cnt_q  [NUM_PRIORITIES];

  // Waiter memory, one ring of LEVEL_DEPTH per level
  logic [IDW-1:0] mem [WORDS];
  logic [IDW-1:0] rdata_q;

  logic [NUM_PRIORITIES-1:0] nonempty;
  logic                      any_ne;
  logic [LVW-1:0]            top_lvl;
  logic [PRIO_W-1:0]         prio_sat;
  logic [AW-1:0]             raddr, waddr;
  logic [SLW-1:0]            tail_cur, head_cur;
  logic [CNW-1:0]            cnt_lk;
  logic                      lk_ok, hand;

  status_e           st_d;
  logic              chg_d, rel_v_d;
  logic [IDW-1:0]    rel_id_d;
  logic [PRIO_W-1:0] rel_p_d;

  // Result registers
  status_e           st_q;
  logic              ov_q, chg_q, rel_v_q;
  logic [IDW-1:0]    oid_q, rel_id_q;
  logic [PRIO_W-1:0] op_q, rel_p_q;

  // Priorities past the last level fold onto it
  assign prio_sat = (thread_priority_i > MAXP_C) ? MAXP_C : thread_priority_i;

  // Highest non-empty level
  always_comb begin
    top_lvl = '0;
    for (int i = 0; i < NUM_PRIORITIES; i++) begin
      nonempty[i] = (cnt_q[i] != '0);
      if (nonempty[i]) top_lvl = LVW'(i);
    end
  end
  assign any_ne = |nonempty;

  // Memory addresses: head of the top level, tail of the request level
  assign head_cur = head_q[top_lvl];
  assign tail_cur = tail_q[lvl_q];
  assign cnt_lk   = cnt_q[lvl_q];
  assign raddr    = AW'(top_lvl) * LD_C + AW'(head_cur);
  assign waddr    = AW'(lvl_q) * LD_C + AW'(tail_cur);

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q  <= command_i;
      tid_q  <= thread_id_i;
      prio_q <= prio_sat;
      lvl_q  <= LVW'(prio_sat);
      top_q  <= top_lvl;
    end
  end

  // Waiter memory: read on capture, enqueue on commit
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) rdata_q <= mem[raddr];
    if (ctrl_i.commit && lk_ok) mem[waddr] <= tid_q;
  end

  // Request evaluation
  always_comb begin
    own_d    = own_q;
    hid_d    = hid_q;
    hbase_d  = hbase_q;
    hcur_d   = hcur_q;
    st_d     = ST_ERROR;
    chg_d    = 1'b0;
    rel_v_d  = 1'b0;
    rel_id_d = '0;
    rel_p_d  = '0;
    lk_ok    = 1'b0;
    hand     = 1'b0;
    if (cmd_q == CMD_LOCK) begin
      if (!own_q) begin
        own_d   = 1'b1;
        hid_d   = tid_q;
        hbase_d = prio_q;
        hcur_d  = prio_q;
        st_d    = ST_GRANTED;
      end else if (cnt_lk != FULL_C) begin
        lk_ok = 1'b1;
        st_d  = ST_QUEUED;
        if (prio_q > hcur_q) begin
          hcur_d = prio_q;
          chg_d  = 1'b1;
        end
      end
    end else if (own_q && (tid_q == hid_q)) begin
      if (hcur_q != hbase_q) begin
        rel_v_d  = 1'b1;
        rel_id_d = hid_q;
        rel_p_d  = hbase_q;
      end
      if (any_ne) begin
        hand    = 1'b1;
        hid_d   = rdata_q;
        hbase_d = PRIO_W'(top_q);
        hcur_d  = PRIO_W'(top_q);
        st_d    = ST_HANDED;
      end else begin
        own_d   = 1'b0;
        hid_d   = '0;
        hbase_d = '0;
        hcur_d  = '0;
        st_d    = ST_FREED;
      end
    end
  end

  // Owner and level state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q   <= 1'b0;
      hid_q   <= '0;
      hbase_q <= '0;
      hcur_q  <= '0;
      for (int i = 0; i < NUM_PRIORITIES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (ctrl_i.commit) begin
      own_q   <= own_d;
      hid_q   <= hid_d;
      hbase_q <= hbase_d;
      hcur_q  <= hcur_d;
      if (lk_ok) begin
        tail_q[lvl_q] <= (tail_cur == LAST_C) ? '0 : tail_cur + 1'b1;
        cnt_q[lvl_q]  <= cnt_lk + 1'b1;
      end
      if (hand) begin
        head_q[top_q] <= (head_q[top_q] == LAST_C) ? '0 : head_q[top_q] + 1'b1;
        cnt_q[top_q]  <= cnt_q[top_q] - 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      st_q     <= st_d;
      ov_q     <= own_d;
      oid_q    <= hid_d;
      op_q     <= hcur_d;
      chg_q    <= chg_d;
      rel_v_q  <= rel_v_d;
      rel_id_q <= rel_id_d;
      rel_p_q  <= rel_p_d;
    end
  end

  assign status_o                 = st_q;
  assign owner_valid_o            = ov_q;
  assign owner_id_o               = oid_q;
  assign owner_priority_o         = op_q;
  assign owner_priority_changed_o = chg_q;
  assign released_valid_o         = rel_v_q;
  assign released_id_o            = rel_id_q;
  assign released_priority_o      = rel_p_q;

  a_free_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !own_q |-> (hid_q == '0) && (hcur_q == '0) && (hbase_q == '0))
    else $error("free mutex keeps owner data");

  a_no_waiters_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !own_q |-> !any_ne)
    else $error("waiters queued on a free mutex");

  a_boost_only_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    own_q |-> (hcur_q >= hbase_q))
    else $error("owner priority below its base");

endmodule

### sv/priority_inheritance_mutex.sv
// A request is taken in the idle state, which registers it and reads the waiter memory;
// the execute step then updates owner, level pointers and memory and loads the result register.
// No new request is taken until the current one has committed to the result register.
// A result waiting on a stalled response channel holds the next request in work.
// Reset (asynchronous, active low) frees the mutex and empties every level queue;
// the waiter memory is not cleared, since the level fill counts guard its entries.
module priority_inheritance_mutex #(
  parameter int unsigned NUM_PRIORITIES = 8,
  parameter int unsigned LEVEL_DEPTH    = 8,
  parameter int unsigned THREAD_ID_BITS = 5
) (
  input logic   clk_i,
  input logic   rst_ni,
  pim_req_if.sink   req_i,
  pim_rsp_if.source rsp_o
);
  import pim_pkg::*;

  pim_ctrl_t ctrl;

  // Sequencing and handshakes
  pim_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .ctrl_o      (ctrl)
  );

  // Owner, level queues and result
  pim_dp #(
    .NUM_PRIORITIES (NUM_PRIORITIES),
    .LEVEL_DEPTH    (LEVEL_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_dp (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .ctrl_i                   (ctrl),
    .command_i                (req_i.command),
    .thread_id_i              (req_i.thread_id),
    .thread_priority_i        (req_i.thread_priority),
    .status_o                 (rsp_o.status),
    .owner_valid_o            (rsp_o.owner_valid),
    .owner_id_o               (rsp_o.owner_id),
    .owner_priority_o         (rsp_o.owner_priority),
    .owner_priority_changed_o (rsp_o.owner_priority_changed),
    .released_valid_o         (rsp_o.released_valid),
    .released_id_o            (rsp_o.released_id),
    .released_priority_o      (rsp_o.released_priority)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pim_pkg::*;

  localparam int unsigned NUM_PRIO    = 8;
  localparam int unsigned DEPTH       = 8;
  localparam int unsigned ID_BITS     = 5;
  localparam int unsigned N_RANDOM    = 1800;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned HOLD_AFTER  = 900;
  localparam int unsigned DRAIN_WAIT  = 10;

  typedef logic [ID_BITS-1:0] tid_t;
  typedef logic [PRIO_W-1:0]  prio_t;

  // Pending request; from_owner means "unlock by whoever owns the mutex then"
  typedef struct packed {
    logic  from_owner;
    logic  command;
    tid_t  thread_id;
    prio_t thread_priority;
  } request_t;

  typedef struct packed {
    status_e status;
    logic    owner_valid;
    tid_t    owner_id;
    prio_t   owner_priority;
    logic    owner_priority_changed;
    logic    released_valid;
    tid_t    released_id;
    prio_t   released_priority;
  } outcome_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pim_req_if #(.ID_BITS(ID_BITS)) req_if ();
  pim_rsp_if #(.ID_BITS(ID_BITS)) rsp_if ();

  priority_inheritance_mutex #(
    .NUM_PRIORITIES(NUM_PRIO),
    .LEVEL_DEPTH   (DEPTH),
    .THREAD_ID_BITS(ID_BITS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #4 clk_i = ~clk_i;

  // Shadow of the mutex: owner, waiter rings per level
  int unsigned held_count;
  tid_t        holder;
  prio_t       holder_base;
  prio_t       holder_cur;
  tid_t        waiters [NUM_PRIO][DEPTH];
  int unsigned lvl_head [NUM_PRIO];
  int unsigned lvl_tail [NUM_PRIO];
  int unsigned lvl_fill [NUM_PRIO];

  request_t    pending[$];
  outcome_t    owed_results[$];
  int unsigned fails;
  int unsigned results_seen;
  int unsigned cyc;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  logic        held_off;
  logic        req_taken;
  logic        calm;

  // Stretch of the run with no idling on either side
  assign calm = (cyc >= 2500) && (cyc < 3500);

  // Applies one request to the shadow and returns the result it must produce
  function automatic outcome_t mutex_step(input logic cmd, input tid_t tid, input prio_t prio_in);
    outcome_t    o;
    int unsigned lv;
    int unsigned slot;
    int          lvl;
    bit          found;
    lv = (prio_in >= NUM_PRIO) ? NUM_PRIO - 1 : prio_in;
    o = '0;
    o.status = ST_ERROR;
    if (cmd == CMD_LOCK) begin
      if (held_count == 0) begin
        held_count  = 1;
        holder      = tid;
        holder_base = prio_t'(lv);
        holder_cur  = prio_t'(lv);
        o.status    = ST_GRANTED;
      end else if (lvl_fill[lv] < DEPTH) begin
        slot = lvl_tail[lv];
        waiters[lv][slot] = tid;
        lvl_tail[lv] = (slot + 1) % DEPTH;
        lvl_fill[lv]++;
        held_count++;
        // waiter above the owner boosts it
        if (lv > holder_cur) begin
          holder_cur = prio_t'(lv);
          o.owner_priority_changed = 1'b1;
        end
        o.status = ST_QUEUED;
      end
    end else if (held_count != 0 && tid == holder) begin
      if (holder_cur != holder_base) begin
        o.released_valid    = 1'b1;
        o.released_id       = holder;
        o.released_priority = holder_base;
      end
      held_count--;
      holder      = '0;
      holder_base = '0;
      holder_cur  = '0;
      o.status    = ST_FREED;
      // hand over to the oldest waiter of the highest busy level
      found = 1'b0;
      for (lvl = int'(NUM_PRIO) - 1; lvl >= 0 && !found; lvl--) begin
        if (lvl_fill[lvl] > 0) begin
          slot          = lvl_head[lvl];
          holder        = waiters[lvl][slot];
          lvl_head[lvl] = (slot + 1) % DEPTH;
          lvl_fill[lvl]--;
          holder_base   = prio_t'(lvl);
          holder_cur    = prio_t'(lvl);
          found         = 1'b1;
          o.status      = ST_HANDED;
        end
      end
      if (!found) held_count = 0;
    end
    if (held_count > 0) begin
      o.owner_valid    = 1'b1;
      o.owner_id       = holder;
      o.owner_priority = holder_cur;
    end
    return o;
  endfunction

  function automatic void queue_request(input bit from_owner, input logic cmd,
                                        input int unsigned tid, input int unsigned prio);
    request_t r;
    r.from_owner      = from_owner;
    r.command         = cmd;
    r.thread_id       = tid_t'(tid);
    r.thread_priority = prio_t'(prio);
    pending.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // Request driver: next request once the current one is taken
  always @(negedge clk_i) begin : req_driver
    request_t nxt;
    if (rst_ni && (!req_if.valid || req_taken)) begin
      if (pending.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
        nxt = pending.pop_front();
        // shadow is current here: every earlier request has been taken
        if (nxt.from_owner && held_count != 0) nxt.thread_id = holder;
        req_if.valid           <= 1'b1;
        req_if.command         <= nxt.command;
        req_if.thread_id       <= nxt.thread_id;
        req_if.thread_priority <= nxt.thread_priority;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Result sink ready, with one long hold-off to back the block up
  always @(negedge clk_i) begin : rsp_ready_driver
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else if (!held_off && results_seen >= HOLD_AFTER) begin
        held_off     <= 1'b1;
        hold_left    <= HOLD_CYCLES;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= calm || ($urandom_range(99) >= 21);
      end
    end
  end

  // Monitor: check results, predict for each request taken
  always @(posedge clk_i) begin : monitor
    outcome_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          want = owed_results.pop_front();
          check_field("status", want.status, rsp_if.status);
          check_field("owner_valid", want.owner_valid, rsp_if.owner_valid);
          check_field("owner_id", want.owner_id, rsp_if.owner_id);
          check_field("owner_priority", want.owner_priority, rsp_if.owner_priority);
          check_field("owner_priority_changed", want.owner_priority_changed,
                      rsp_if.owner_priority_changed);
          check_field("released_valid", want.released_valid, rsp_if.released_valid);
          check_field("released_id", want.released_id, rsp_if.released_id);
          check_field("released_priority", want.released_priority,
                      rsp_if.released_priority);
        end
      end
      if (req_if.valid && req_if.ready) begin
        owed_results.push_back(mutex_step(req_if.command, req_if.thread_id,
                                          req_if.thread_priority));
      end
      req_taken <= req_if.valid && req_if.ready;
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      cyc <= cyc + 1;
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned lock_pct;
    int unsigned lo;
    int unsigned hi;
    int unsigned roll;
    req_if.valid           = 1'b0;
    req_if.command         = CMD_LOCK;
    req_if.thread_id       = '0;
    req_if.thread_priority = '0;
    rsp_if.ready           = 1'b0;
    held_count   = 0;
    holder       = '0;
    holder_base  = '0;
    holder_cur   = '0;
    fails        = 0;
    results_seen = 0;
    cyc          = 0;
    quiet_cycles = 0;
    hold_left    = 0;
    held_off     = 1'b0;
    req_taken    = 1'b0;
    for (n = 0; n < NUM_PRIO; n++) begin
      lvl_head[n] = 0;
      lvl_tail[n] = 0;
      lvl_fill[n] = 0;
    end

    // Directed: unlock of a free mutex
    queue_request(0, CMD_UNLOCK, 5, 3);
    // grant at the lowest level, boost from the top level
    queue_request(0, CMD_LOCK, 0, 0);
    queue_request(0, CMD_LOCK, 31, 7);
    // unlock by a thread that does not own it
    queue_request(0, CMD_UNLOCK, 31, 7);
    // owner locking again gets queued
    queue_request(0, CMD_LOCK, 0, 0);
    // fill the top level, then overflow it
    for (n = 1; n <= 7; n++) queue_request(0, CMD_LOCK, n, 7);
    queue_request(0, CMD_LOCK, 8, 7);
    // boosted owner releases and hands over
    queue_request(0, CMD_UNLOCK, 0, 0);
    queue_request(0, CMD_LOCK, 9, 3);
    // drain every waiter until the mutex is free
    repeat (10) queue_request(1, CMD_UNLOCK, 0, 0);

    // Random: phases with their own lock mix and priority window
    lock_pct = 50;
    lo = 0;
    hi = 7;
    for (n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0) begin
        lock_pct = $urandom_range(85, 25);
        lo = $urandom_range(7);
        hi = $urandom_range(7, lo);
      end
      roll = $urandom_range(99);
      if (roll < lock_pct)
        queue_request(0, CMD_LOCK, $urandom_range(31), $urandom_range(hi, lo));
      else if (roll < 92)
        queue_request(1, CMD_UNLOCK, $urandom_range(31), $urandom_range(7));
      else if (roll < 96)
        queue_request(0, CMD_UNLOCK, $urandom_range(31), $urandom_range(7));
      else
        queue_request(0, CMD_LOCK, $urandom_range(31), $urandom_range(7));
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending.size() == 0 && !req_if.valid);
    wait (owed_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fails == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
